// File: rtl/cale_pkg.sv
// ----------------------------------------------------------------------------
// cale_pkg: shared types and constants of the cursor array list engine
// Store depth, field widths, request and status codes, and the structs
// passed between the sequencer, the element store and the top level.
// ----------------------------------------------------------------------------
package cale_pkg;

   // Store geometry
   localparam int DEPTH  = 1024;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int REQ_W  = 4;
   localparam int STAT_W = 3;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_READ_CUR   = 4'd0,
      REQ_WRITE_CUR  = 4'd1,
      REQ_PREV       = 4'd2,
      REQ_NEXT       = 4'd3,
      REQ_FIRST      = 4'd4,
      REQ_LAST       = 4'd5,
      REQ_DELETE     = 4'd6,
      REQ_INS_BEFORE = 4'd7,
      REQ_INS_AFTER  = 4'd8,
      REQ_READ_IDX   = 4'd9,
      REQ_WRITE_IDX  = 4'd10
   } req_code_type;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 3'd0,
      STAT_EMPTY = 3'd1,
      STAT_RANGE = 3'd2,
      STAT_FULL  = 3'd3,
      STAT_BOUND = 3'd4
   } status_type;

   // One result item
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_data;
      logic [CNT_W-1:0]  count;
      logic [IDX_W-1:0]  cursor_pos;
   } rsp_type;

   // Element store access for one cycle
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

endpackage

// File: rtl/cale_if.sv
// ----------------------------------------------------------------------------
// cale_if: request and result channels of the cursor array list engine
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cale_req_if;
   logic                              valid;
   logic                              ready;
   logic [cale_pkg::REQ_W-1:0]        req_type;
   logic signed [cale_pkg::DATA_W-1:0] value;
   logic [cale_pkg::IDX_W-1:0]        position;

   modport source (output valid, output req_type, output value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input value, input position,
                   output ready);
endinterface

interface cale_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cale_pkg::STAT_W-1:0]        status;
   logic signed [cale_pkg::DATA_W-1:0] read_data;
   logic [cale_pkg::CNT_W-1:0]         count;
   logic [cale_pkg::IDX_W-1:0]         cursor_pos;

   modport source (output valid, output status, output read_data, output count,
                   output cursor_pos, input ready);
   modport sink   (input valid, input status, input read_data, input count,
                   input cursor_pos, output ready);
endinterface

// File: rtl/cale_store.sv
// ----------------------------------------------------------------------------
// cale_store: element store
// DEPTH x 32 memory, one write port and one read port with registered data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module cale_store (
   input  logic                          clock,
   input  cale_pkg::mem_req_type         mem_req,
   output logic [cale_pkg::DATA_W-1:0]   mem_rdata
);

   logic [cale_pkg::DATA_W-1:0] mem [cale_pkg::DEPTH];
   logic [cale_pkg::DATA_W-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// File: rtl/cale_seq.sv
// ----------------------------------------------------------------------------
// cale_seq: request sequencer
// Decodes a request against length and cursor, moves elements through the
// store one per cycle for insert and delete, then fetches the element to
// report and hands the finished result to the output stage.
// ----------------------------------------------------------------------------
module cale_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cale_pkg::REQ_W-1:0]         req_code,
   input  logic [cale_pkg::DATA_W-1:0]        req_value,
   input  logic [cale_pkg::IDX_W-1:0]         req_position,
   output cale_pkg::mem_req_type              mem_req,
   input  logic [cale_pkg::DATA_W-1:0]        mem_rdata,
   input  logic                               rsp_free,
   output logic                               rsp_load,
   output cale_pkg::rsp_type                  rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SHIFT  = 5'b00010,
      ST_PUT    = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [cale_pkg::CNT_W-1:0]      len_ff, len_in;
   logic [cale_pkg::IDX_W-1:0]      cur_ff, cur_in;
   logic [cale_pkg::STAT_W-1:0]     status_ff, status_in;
   logic                            idx_read_ff, idx_read_in;
   logic                            fwd_ff, fwd_in;
   logic [cale_pkg::CNT_W-1:0]      remain_ff, remain_in;
   logic [cale_pkg::IDX_W-1:0]      rd_addr_ff, rd_addr_in;
   logic [cale_pkg::IDX_W-1:0]      wr_addr_ff, wr_addr_in;
   logic                            wr_pend_ff, wr_pend_in;
   logic [cale_pkg::IDX_W-1:0]      put_addr_ff, put_addr_in;
   logic [cale_pkg::IDX_W-1:0]      pos_ff, pos_in;
   logic [cale_pkg::DATA_W-1:0]     val_ff, val_in;

   logic                            empty;
   logic                            at_last;
   logic                            pos_bad;
   logic                            full;
   logic [cale_pkg::CNT_W-1:0]      cur_ext;
   logic [cale_pkg::IDX_W-1:0]      cur_inc;
   logic [cale_pkg::IDX_W-1:0]      len_dec;
   logic [cale_pkg::IDX_W-1:0]      gap_at;

   // List conditions seen by an arriving request
   assign cur_ext = {1'b0, cur_ff};
   assign cur_inc = cur_ff + 1'b1;
   assign len_dec = cale_pkg::IDX_W'(len_ff - 1'b1);
   assign empty   = (len_ff == '0);
   assign at_last = ((cur_ext + 1'b1) >= len_ff);
   assign pos_bad = ({1'b0, req_position} >= len_ff);
   assign full    = (len_ff >= cale_pkg::CNT_W'(cale_pkg::DEPTH));

   assign req_ready = (state_ff == ST_IDLE);

   // Next state, store access and result
   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      cur_in      = cur_ff;
      status_in   = status_ff;
      idx_read_in = idx_read_ff;
      fwd_in      = fwd_ff;
      remain_in   = remain_ff;
      rd_addr_in  = rd_addr_ff;
      wr_addr_in  = wr_addr_ff;
      wr_pend_in  = 1'b0;
      put_addr_in = put_addr_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      gap_at      = '0;
      mem_req     = '0;
      rsp_load    = 1'b0;
      rsp_data    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in   = cale_pkg::STAT_OK;
               idx_read_in = 1'b0;
               pos_in      = req_position;
               val_in      = req_value;
               remain_in   = '0;
               state_in    = ST_FETCH;
               gap_at      = (req_code == cale_pkg::REQ_INS_BEFORE) ? cur_ff : cur_inc;
               unique case (req_code)
                  cale_pkg::REQ_READ_CUR: begin
                     if (empty) status_in = cale_pkg::STAT_EMPTY;
                  end
                  cale_pkg::REQ_WRITE_CUR: begin
                     if (empty) begin
                        status_in = cale_pkg::STAT_EMPTY;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = cur_ff;
                        mem_req.wdata = req_value;
                     end
                  end
                  cale_pkg::REQ_PREV: begin
                     if (empty) status_in = cale_pkg::STAT_EMPTY;
                     else if (cur_ff == '0) status_in = cale_pkg::STAT_BOUND;
                     else cur_in = cur_ff - 1'b1;
                  end
                  cale_pkg::REQ_NEXT: begin
                     if (empty) status_in = cale_pkg::STAT_EMPTY;
                     else if (at_last) status_in = cale_pkg::STAT_BOUND;
                     else cur_in = cur_inc;
                  end
                  cale_pkg::REQ_FIRST: begin
                     if (empty) status_in = cale_pkg::STAT_EMPTY;
                     else cur_in = '0;
                  end
                  cale_pkg::REQ_LAST: begin
                     if (empty) status_in = cale_pkg::STAT_EMPTY;
                     else cur_in = len_dec;
                  end
                  cale_pkg::REQ_DELETE: begin
                     if (empty) begin
                        status_in = cale_pkg::STAT_EMPTY;
                     end else if (len_ff == cale_pkg::CNT_W'(1)) begin
                        len_in = '0;
                        cur_in = '0;
                     end else if (at_last) begin
                        len_in = len_ff - 1'b1;
                        cur_in = cur_ff - 1'b1;
                     end else begin
                        // close the gap: move cur+1 .. len-1 one place left
                        len_in     = len_ff - 1'b1;
                        remain_in  = len_ff - cur_ext - 1'b1;
                        rd_addr_in = cur_inc;
                        fwd_in     = 1'b1;
                        state_in   = ST_SHIFT;
                     end
                  end
                  cale_pkg::REQ_INS_BEFORE, cale_pkg::REQ_INS_AFTER: begin
                     if (empty) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = '0;
                        mem_req.wdata = req_value;
                        len_in        = cale_pkg::CNT_W'(1);
                        cur_in        = '0;
                     end else if (full) begin
                        status_in = cale_pkg::STAT_FULL;
                     end else begin
                        // open the gap: move at .. len-1 one place right
                        len_in      = len_ff + 1'b1;
                        remain_in   = len_ff - {1'b0, gap_at};
                        rd_addr_in  = len_dec;
                        put_addr_in = gap_at;
                        fwd_in      = 1'b0;
                        state_in    = ST_SHIFT;
                        if (req_code == cale_pkg::REQ_INS_BEFORE) cur_in = cur_inc;
                     end
                  end
                  cale_pkg::REQ_READ_IDX: begin
                     if (pos_bad) status_in = cale_pkg::STAT_RANGE;
                     else idx_read_in = 1'b1;
                  end
                  cale_pkg::REQ_WRITE_IDX: begin
                     if (pos_bad) begin
                        status_in = cale_pkg::STAT_RANGE;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = req_position;
                        mem_req.wdata = req_value;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // read one element, write it next to its old place in the following cycle
            mem_req.we    = wr_pend_ff;
            mem_req.waddr = wr_addr_ff;
            mem_req.wdata = mem_rdata;
            if (remain_ff != '0) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = rd_addr_ff;
               wr_pend_in    = 1'b1;
               wr_addr_in    = fwd_ff ? (rd_addr_ff - 1'b1) : (rd_addr_ff + 1'b1);
               rd_addr_in    = fwd_ff ? (rd_addr_ff + 1'b1) : (rd_addr_ff - 1'b1);
               remain_in     = remain_ff - 1'b1;
            end else begin
               state_in = fwd_ff ? ST_FETCH : ST_PUT;
            end
         end

         ST_PUT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = put_addr_ff;
            mem_req.wdata = val_ff;
            state_in      = ST_FETCH;
         end

         ST_FETCH: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_read_ff ? pos_ff : cur_ff;
            state_in      = ST_RESULT;
         end

         ST_RESULT: begin
            rsp_data.status     = status_ff;
            rsp_data.read_data  = (len_ff == '0) ? '0 : mem_rdata;
            rsp_data.count      = len_ff;
            rsp_data.cursor_pos = cur_ff;
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_ff     <= '0;
         cur_ff     <= '0;
         wr_pend_ff <= 1'b0;
         remain_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         cur_ff     <= cur_in;
         wr_pend_ff <= wr_pend_in;
         remain_ff  <= remain_in;
      end
   end

   // Per-request working registers
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      idx_read_ff <= idx_read_in;
      fwd_ff      <= fwd_in;
      rd_addr_ff  <= rd_addr_in;
      wr_addr_ff  <= wr_addr_in;
      put_addr_ff <= put_addr_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
   end

endmodule

// File: rtl/cursor_array_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_array_list_engine: ordered list in a fixed store, with a cursor
// Top level: request sequencer, element store and result output register.
//
//   channel   dir  handshake     payload
//   req_ch    in   valid/ready   req_type[4], value[32], position[10]
//   rsp_ch    out  valid/ready   status[3], read_data[32], count[11],
//                                cursor_pos[10]
//
// Every item passes the decode, fetch and result steps; a delete that
// moves m elements adds a shift and an insert that opens a gap a shift
// and a put (m up to DEPTH-1). Cursor moves, reads, writes, a delete at
// the end, an insert into an empty list and a refused insert move none;
// the single store port pair moves one element per cycle.
// Reset clears length and cursor; store contents are not cleared.
// req_ch is ready only while the sequencer is idle; a held result in the
// output register stalls the sequencer in its last step.
// ----------------------------------------------------------------------------
module cursor_array_list_engine (
   input  logic           clock,
   input  logic           reset,
   cale_req_if.sink       req_ch,
   cale_rsp_if.source     rsp_ch
);

   cale_pkg::mem_req_type             mem_req;
   logic [cale_pkg::DATA_W-1:0]       mem_rdata;
   logic                              rsp_free;
   logic                              rsp_load;
   cale_pkg::rsp_type                 rsp_data;
   logic                              rsp_valid_ff;
   cale_pkg::rsp_type                 rsp_ff;

   cale_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .req_code     (req_ch.req_type),
      .req_value    (req_ch.value),
      .req_position (req_ch.position),
      .mem_req      (mem_req),
      .mem_rdata    (mem_rdata),
      .rsp_free     (rsp_free),
      .rsp_load     (rsp_load),
      .rsp_data     (rsp_data)
   );

   cale_store u_store (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   // Output register: free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_data;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_ff.status;
   assign rsp_ch.read_data  = rsp_ff.read_data;
   assign rsp_ch.count      = rsp_ff.count;
   assign rsp_ch.cursor_pos = rsp_ff.cursor_pos;

endmodule

// File: tb/tb_cursor_array_list_engine.sv
// ----------------------------------------------------------------------------
// tb_cursor_array_list_engine: self-checking bench for the cursor array list
// A queue of request items feeds a clocked driver; every accepted item runs
// through a behavioral list with cursor, and the expected result is queued.
// A clocked monitor compares every accepted result field by field. Stimulus:
// directed corner cases, random traffic on short lists, then a closing set
// of cursor, index and shift requests. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_cursor_array_list_engine;

   // Unused request codes start here and run to the top of the field
   localparam logic [cale_pkg::REQ_W-1:0] REQ_NONE_LO = 4'd11;
   localparam logic [cale_pkg::REQ_W-1:0] REQ_NONE_HI = 4'd15;

   localparam int RAND_ITEMS   = 530;
   localparam int IDLE_PCT     = 11;
   localparam int SEND_QUIET_LO = 150;
   localparam int SEND_QUIET_HI = 320;
   localparam int RECV_QUIET_LO = 200;
   localparam int RECV_QUIET_HI = 360;
   localparam int HOLD_AT      = 420;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 5000000;

   typedef struct packed {
      logic [cale_pkg::REQ_W-1:0]  kind;
      logic [cale_pkg::DATA_W-1:0] value;
      logic [cale_pkg::IDX_W-1:0]  position;
   } list_req_type;

   logic clock;
   logic reset;

   cale_req_if req_ch ();
   cale_rsp_if rsp_ch ();

   cursor_array_list_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   list_req_type      pending_reqs[$];
   cale_pkg::rsp_type expected_rsps[$];

   // Behavioral list: elements, length, cursor
   logic [cale_pkg::DATA_W-1:0] elems [cale_pkg::DEPTH];
   int unsigned       n_elems = 0;
   int unsigned       cur = 0;

   // Length as seen by the stimulus generator, used to steer list size
   int unsigned gen_len = 0;

   int n_sent = 0;
   int n_rcvd = 0;
   int n_errors = 0;
   int n_cycles = 0;
   int hold_left = 0;
   logic held = 1'b0;
   cale_pkg::rsp_type want;
   list_req_type      acc_req;

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Apply one request to the behavioral list and return its result
   function automatic cale_pkg::rsp_type list_apply(input list_req_type r);
      cale_pkg::rsp_type           res;
      cale_pkg::status_type        st;
      logic                        have_rd;
      logic [cale_pkg::DATA_W-1:0] rd;
      int unsigned                 at;
      int unsigned                 i;
      st = cale_pkg::STAT_OK;
      have_rd = 1'b0;
      rd = '0;
      case (r.kind)
         cale_pkg::REQ_READ_CUR, cale_pkg::REQ_WRITE_CUR, cale_pkg::REQ_PREV,
         cale_pkg::REQ_NEXT, cale_pkg::REQ_FIRST, cale_pkg::REQ_LAST,
         cale_pkg::REQ_DELETE: begin
            if (n_elems == 0) begin
               st = cale_pkg::STAT_EMPTY;
            end else begin
               case (r.kind)
                  cale_pkg::REQ_WRITE_CUR: elems[cur] = r.value;
                  cale_pkg::REQ_PREV: begin
                     if (cur == 0) st = cale_pkg::STAT_BOUND;
                     else cur = cur - 1;
                  end
                  cale_pkg::REQ_NEXT: begin
                     if (cur + 1 >= n_elems) st = cale_pkg::STAT_BOUND;
                     else cur = cur + 1;
                  end
                  cale_pkg::REQ_FIRST: cur = 0;
                  cale_pkg::REQ_LAST:  cur = n_elems - 1;
                  cale_pkg::REQ_DELETE: begin
                     if (n_elems == 1) begin
                        n_elems = 0;
                        cur = 0;
                     end else if (cur + 1 >= n_elems) begin
                        n_elems = n_elems - 1;
                        cur = cur - 1;
                     end else begin
                        for (i = cur; i + 1 < n_elems; i++) elems[i] = elems[i + 1];
                        n_elems = n_elems - 1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         cale_pkg::REQ_INS_BEFORE, cale_pkg::REQ_INS_AFTER: begin
            if (n_elems == 0) begin
               elems[0] = r.value;
               n_elems = 1;
               cur = 0;
            end else if (n_elems >= cale_pkg::DEPTH) begin
               st = cale_pkg::STAT_FULL;
            end else begin
               at = (r.kind == cale_pkg::REQ_INS_BEFORE) ? cur : cur + 1;
               for (i = n_elems; i > at; i--) elems[i] = elems[i - 1];
               elems[at] = r.value;
               if (r.kind == cale_pkg::REQ_INS_BEFORE) cur = cur + 1;
               n_elems = n_elems + 1;
            end
         end
         cale_pkg::REQ_READ_IDX, cale_pkg::REQ_WRITE_IDX: begin
            if (r.position >= n_elems) begin
               st = cale_pkg::STAT_RANGE;
            end else if (r.kind == cale_pkg::REQ_READ_IDX) begin
               have_rd = 1'b1;
               rd = elems[r.position];
            end else begin
               elems[r.position] = r.value;
            end
         end
         default: ;
      endcase
      if (!have_rd) rd = (n_elems == 0) ? '0 : elems[cur];
      res.status     = st;
      res.read_data  = rd;
      res.count      = cale_pkg::CNT_W'(n_elems);
      res.cursor_pos = cale_pkg::IDX_W'(cur);
      return res;
   endfunction

   // Queue one request and track the list length it leaves behind
   task automatic push_req(input logic [cale_pkg::REQ_W-1:0] kind,
                           input logic [cale_pkg::DATA_W-1:0] v,
                           input logic [cale_pkg::IDX_W-1:0] p);
      list_req_type r;
      r.kind = kind;
      r.value = v;
      r.position = p;
      pending_reqs.push_back(r);
      if ((kind == cale_pkg::REQ_INS_BEFORE || kind == cale_pkg::REQ_INS_AFTER) &&
          gen_len < cale_pkg::DEPTH)
         gen_len++;
      else if (kind == cale_pkg::REQ_DELETE && gen_len > 0)
         gen_len--;
   endtask

   // Element data, with the extremes showing up often
   function automatic logic [cale_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Index: mostly inside the list, sometimes anywhere in the field
   function automatic logic [cale_pkg::IDX_W-1:0] pick_index();
      if (gen_len > 0 && $urandom_range(0, 3) != 0)
         return cale_pkg::IDX_W'($urandom_range(0, gen_len - 1));
      return cale_pkg::IDX_W'($urandom_range(0, cale_pkg::DEPTH - 1));
   endfunction

   // Stimulus, reset and end of run
   initial begin
      int k;
      int roll;
      int ins_w;
      int del_w;
      int drain_left;
      reset = 1'b1;
      drain_left = 0;

      // Directed: empty list, first inserts, cursor ends, index checks, deletes
      push_req(cale_pkg::REQ_READ_CUR,   '0, '0);
      push_req(cale_pkg::REQ_WRITE_CUR,  32'h1234_5678, '0);
      push_req(cale_pkg::REQ_PREV,       '0, '0);
      push_req(cale_pkg::REQ_NEXT,       '0, '0);
      push_req(cale_pkg::REQ_FIRST,      '0, '0);
      push_req(cale_pkg::REQ_LAST,       '0, '0);
      push_req(cale_pkg::REQ_DELETE,     '0, '0);
      push_req(cale_pkg::REQ_READ_IDX,   '0, '0);
      push_req(cale_pkg::REQ_WRITE_IDX,  '1, '1);
      push_req(cale_pkg::REQ_INS_AFTER,  32'h7FFF_FFFF, '0);
      push_req(cale_pkg::REQ_INS_BEFORE, 32'h8000_0000, '0);
      push_req(cale_pkg::REQ_INS_AFTER,  '0, '0);
      push_req(cale_pkg::REQ_PREV,       '0, '0);
      push_req(cale_pkg::REQ_PREV,       '0, '0);
      push_req(cale_pkg::REQ_LAST,       '0, '0);
      push_req(cale_pkg::REQ_NEXT,       '0, '0);
      push_req(cale_pkg::REQ_WRITE_CUR,  '1, '0);
      push_req(cale_pkg::REQ_READ_IDX,   '0, cale_pkg::IDX_W'(1));
      push_req(cale_pkg::REQ_WRITE_IDX,  32'h5A5A_A5A5, '0);
      push_req(cale_pkg::REQ_READ_IDX,   '0, cale_pkg::IDX_W'(3));
      push_req(REQ_NONE_LO,              '1, '1);
      push_req(REQ_NONE_HI,              '0, '0);
      push_req(cale_pkg::REQ_LAST,       '0, '0);
      push_req(cale_pkg::REQ_DELETE,     '0, '0);
      push_req(cale_pkg::REQ_FIRST,      '0, '0);
      push_req(cale_pkg::REQ_DELETE,     '0, '0);
      push_req(cale_pkg::REQ_DELETE,     '0, '0);

      // Random traffic on short lists, with an occasional drain to empty
      for (k = 0; k < RAND_ITEMS; k++) begin
         ins_w = (gen_len < 8) ? 35 : (gen_len > 40) ? 8 : 20;
         del_w = (gen_len > 40) ? 30 : 12;
         roll = $urandom_range(0, 99);
         if (drain_left == 0 && $urandom_range(0, 49) == 0) drain_left = gen_len + 1;
         if (drain_left > 0) begin
            push_req(cale_pkg::REQ_DELETE, pick_value(), pick_index());
            drain_left--;
         end else if (roll < 4) begin
            push_req(cale_pkg::REQ_W'($urandom_range(REQ_NONE_LO, REQ_NONE_HI)),
                     pick_value(), pick_index());
         end else if (roll < 4 + ins_w) begin
            push_req($urandom_range(0, 1) ? cale_pkg::REQ_INS_BEFORE :
                     cale_pkg::REQ_INS_AFTER, pick_value(), pick_index());
         end else if (roll < 4 + ins_w + del_w) begin
            push_req(cale_pkg::REQ_DELETE, pick_value(), pick_index());
         end else if (roll < 29 + ins_w + del_w) begin
            push_req(cale_pkg::REQ_W'($urandom_range(cale_pkg::REQ_PREV, cale_pkg::REQ_LAST)),
                     pick_value(), pick_index());
         end else if (roll < 41 + ins_w + del_w) begin
            push_req($urandom_range(0, 1) ? cale_pkg::REQ_READ_CUR :
                     cale_pkg::REQ_WRITE_CUR, pick_value(), pick_index());
         end else begin
            push_req($urandom_range(0, 1) ? cale_pkg::REQ_READ_IDX :
                     cale_pkg::REQ_WRITE_IDX, pick_value(), pick_index());
         end
      end

      // Closing set: shifts from both ends, cursor moves, top-of-field indexes
      push_req(cale_pkg::REQ_INS_BEFORE, pick_value(), pick_index());
      push_req(cale_pkg::REQ_INS_AFTER,  pick_value(), pick_index());
      push_req(cale_pkg::REQ_NEXT,       pick_value(), pick_index());
      push_req(cale_pkg::REQ_READ_IDX,   pick_value(), cale_pkg::IDX_W'(cale_pkg::DEPTH - 1));
      push_req(cale_pkg::REQ_WRITE_IDX,  pick_value(), cale_pkg::IDX_W'(cale_pkg::DEPTH - 1));
      push_req(cale_pkg::REQ_READ_CUR,   pick_value(), pick_index());
      push_req(cale_pkg::REQ_FIRST,      pick_value(), pick_index());
      push_req(cale_pkg::REQ_PREV,       pick_value(), pick_index());
      push_req(cale_pkg::REQ_INS_AFTER,  pick_value(), pick_index());
      push_req(cale_pkg::REQ_DELETE,     pick_value(), pick_index());
      push_req(cale_pkg::REQ_INS_BEFORE, pick_value(), pick_index());
      push_req(cale_pkg::REQ_INS_AFTER,  pick_value(), pick_index());
      push_req(cale_pkg::REQ_NEXT,       pick_value(), pick_index());
      push_req(cale_pkg::REQ_DELETE,     pick_value(), pick_index());
      push_req(cale_pkg::REQ_INS_AFTER,  pick_value(), pick_index());
      push_req(cale_pkg::REQ_LAST,       pick_value(), pick_index());
      push_req(cale_pkg::REQ_DELETE,     pick_value(), pick_index());
      push_req(cale_pkg::REQ_READ_IDX,   pick_value(), cale_pkg::IDX_W'(cale_pkg::DEPTH - 1));
      push_req(cale_pkg::REQ_READ_IDX,   pick_value(), cale_pkg::IDX_W'(cale_pkg::DEPTH - 2));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0)
         $display("tb_cursor_array_list_engine: clean");
      else
         $display("tb_cursor_array_list_engine: errors");
      $finish;
   end

   // Driver: predict on acceptance, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid    <= 1'b0;
         req_ch.req_type <= '0;
         req_ch.value    <= '0;
         req_ch.position <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            acc_req.kind     = req_ch.req_type;
            acc_req.value    = req_ch.value;
            acc_req.position = req_ch.position;
            expected_rsps.push_back(list_apply(acc_req));
            n_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 &&
                ((n_sent >= SEND_QUIET_LO && n_sent < SEND_QUIET_HI) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_ch.valid    <= 1'b1;
               req_ch.req_type <= pending_reqs[0].kind;
               req_ch.value    <= pending_reqs[0].value;
               req_ch.position <= pending_reqs[0].position;
               void'(pending_reqs.pop_front());
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result, then set ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result item: status %0d, count %0d",
                      rsp_ch.status, rsp_ch.count);
               n_errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  n_errors++;
               end
               if (rsp_ch.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_ch.read_data);
                  n_errors++;
               end
               if (rsp_ch.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                  n_errors++;
               end
               if (rsp_ch.cursor_pos !== want.cursor_pos) begin
                  $error("cursor_pos: expected %0d, got %0d", want.cursor_pos,
                         rsp_ch.cursor_pos);
                  n_errors++;
               end
            end
            n_rcvd++;
         end
         // One long hold-off so the block backs up into its input
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!held && n_rcvd == HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            held <= 1'b1;
         end else begin
            rsp_ch.ready <= (n_rcvd >= RECV_QUIET_LO && n_rcvd < RECV_QUIET_HI) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles == CYCLE_LIMIT) begin
         $display("tb_cursor_array_list_engine: errors");
         $finish;
      end
   end

endmodule

// File: cursor_array_list_engine.f
rtl/cale_pkg.sv
rtl/cale_if.sv
rtl/cale_store.sv
rtl/cale_seq.sv
rtl/cursor_array_list_engine.sv
tb/tb_cursor_array_list_engine.sv
